>>> hw/rtl/dual_channel_gaze_direction_tracker_macros.svh
// ---------------------------------------------------------------------------
// gaze tracker assertion macros
// shared concurrent assertion forms for the tracker checkers
// ---------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_GAZE_DIRECTION_TRACKER_MACROS_SVH
`define DUAL_CHANNEL_GAZE_DIRECTION_TRACKER_MACROS_SVH

// property checked outside reset
`define GDT_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// property checked at every edge, reset included
`define GDT_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

>>> hw/rtl/gdt_pkg.sv
// ---------------------------------------------------------------------------
// gdt_pkg
// types, codes and reset levels shared by the gaze tracker modules
// ---------------------------------------------------------------------------
`default_nettype none

package gdt_pkg;

  localparam int BLOCK_SAMPLES_DEF = 16;
  localparam int SAMPLE_BITS_DEF   = 10;
  localparam int LEVEL_W           = 10;
  localparam int CFG_IDX_W         = 3;

  localparam logic [LEVEL_W-1:0] LEFT_RELEASE_RST  = 10'd420;
  localparam logic [LEVEL_W-1:0] LEFT_TRIGGER_RST  = 10'd390;
  localparam logic [LEVEL_W-1:0] RIGHT_RELEASE_RST = 10'd310;
  localparam logic [LEVEL_W-1:0] RIGHT_TRIGGER_RST = 10'd260;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_RELEASE  = 3'd0,
    CFG_LEFT_TRIGGER  = 3'd1,
    CFG_RIGHT_RELEASE = 3'd2,
    CFG_RIGHT_TRIGGER = 3'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    GAZE_CENTER = 2'd0,
    GAZE_RIGHT  = 2'd1,
    GAZE_LEFT   = 2'd2
  } dir_t;

  typedef struct packed {
    logic take;
    logic flush;
  } lane_ctl_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] left_release;
    logic [LEVEL_W-1:0] left_trigger;
    logic [LEVEL_W-1:0] right_release;
    logic [LEVEL_W-1:0] right_trigger;
  } levels_t;

  typedef struct packed {
    dir_t               gaze_direction;
    logic               direction_changed;
    logic [LEVEL_W-1:0] reported_level;
    logic               averages_updated;
    logic [LEVEL_W-1:0] right_average;
    logic [LEVEL_W-1:0] left_average;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/gdt_lane.sv
// ---------------------------------------------------------------------------
// gdt_lane
// one detector channel: block accumulator and block mean
// ---------------------------------------------------------------------------
`default_nettype none

module gdt_lane import gdt_pkg::*; #(
  parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire lane_ctl_t              ctl,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic      [SAMPLE_BITS-1:0] mean_now
);

  localparam int BLK_LOG = $clog2(BLOCK_SAMPLES);
  localparam int SUM_W   = SAMPLE_BITS + BLK_LOG;
  localparam int SHIFT   = SUM_W + BLK_LOG;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // rounded-up reciprocal, exact for every sum below 2**SUM_W
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(BLOCK_SAMPLES) - 64'd1) / BLOCK_SAMPLES;
  localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] mean;
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] quotient;

  assign prod     = {{RECIP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP_K};
  assign quotient = prod[SHIFT +: SAMPLE_BITS];
  assign mean_now = ctl.flush ? quotient : mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      mean <= '0;
    end else if (ctl.take) begin
      if (ctl.flush) begin
        mean <= quotient;
        sum  <= '0;
      end else begin
        sum <= sum + SUM_W'(sample);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/gdt_dir.sv
// ---------------------------------------------------------------------------
// gdt_dir
// merges both lane means into the center/right/left hysteresis machine
// ---------------------------------------------------------------------------
`default_nettype none

module gdt_dir import gdt_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire lane_ctl_t              ctl,
  input  wire levels_t                levels,
  input  wire logic [SAMPLE_BITS-1:0] right_mean,
  input  wire logic [SAMPLE_BITS-1:0] left_mean,
  output result_t                     res
);

  localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

  dir_t             dir;
  dir_t             dir_next;
  logic             changed;
  logic [CMP_W-1:0] level;
  logic [CMP_W-1:0] r_mean;
  logic [CMP_W-1:0] l_mean;

  assign r_mean = CMP_W'(right_mean);
  assign l_mean = CMP_W'(left_mean);

  always_ff @(posedge clk) begin
    if (rst) begin
      dir <= GAZE_CENTER;
    end else if (ctl.take) begin
      dir <= dir_next;
    end
  end

  always_comb begin
    dir_next = dir;
    changed  = 1'b0;
    level    = '0;
    unique case (dir)
      GAZE_CENTER: begin
        // right wins when both channels trigger
        if (r_mean < CMP_W'(levels.right_trigger)) begin
          dir_next = GAZE_RIGHT;
          changed  = 1'b1;
          level    = r_mean;
        end else if (l_mean < CMP_W'(levels.left_trigger)) begin
          dir_next = GAZE_LEFT;
          changed  = 1'b1;
          level    = l_mean;
        end
      end
      GAZE_RIGHT: begin
        if (r_mean > CMP_W'(levels.right_release)) begin
          dir_next = GAZE_CENTER;
          changed  = 1'b1;
          level    = r_mean;
        end
      end
      GAZE_LEFT: begin
        if (l_mean > CMP_W'(levels.left_release)) begin
          dir_next = GAZE_CENTER;
          changed  = 1'b1;
          level    = l_mean;
        end
      end
      default: begin
        dir_next = dir;
      end
    endcase
  end

  always_comb begin
    res.gaze_direction    = dir_next;
    res.direction_changed = changed;
    res.reported_level    = level[LEVEL_W-1:0];
    res.averages_updated  = ctl.flush;
    res.right_average     = r_mean[LEVEL_W-1:0];
    res.left_average      = l_mean[LEVEL_W-1:0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/dual_channel_gaze_direction_tracker.sv
// ---------------------------------------------------------------------------
// dual channel gaze direction tracker
// Block-averages a right and a left detector and tracks gaze direction.
// Input request: right_sample and left_sample on in_valid/in_ready. Every
//   request yields exactly one result request on out_valid/out_ready.
// Config: cfg_valid/cfg_ready with cfg_index/cfg_data, always ready; index 0
//   left release, 1 left trigger, 2 right release, 3 right trigger, others
//   ignored. Write only while no request is in flight.
// Result: the result of each taken request is registered into the result queue.
// Throughput: one request per cycle while in_ready is high; the lane add, the
//   mean multiply and the threshold compare all complete for each request as it is taken.
// Every BLOCK_SAMPLES+1 requests the last one of the block refreshes both
//   means instead of adding its samples.
// Stall: a two-entry result queue keeps in_ready high while one result
//   waits; in_ready drops only when both entries are full.
// Reset: levels return to 420/390/310/260, sums, means and count clear,
//   direction goes to center, the result queue empties.
// ---------------------------------------------------------------------------
`default_nettype none

module dual_channel_gaze_direction_tracker import gdt_pkg::*; #(
  parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] right_sample,
  input  wire logic [SAMPLE_BITS-1:0] left_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  gaze_direction,
  output logic                        direction_changed,
  output logic [LEVEL_W-1:0]          reported_level,
  output logic                        averages_updated,
  output logic [LEVEL_W-1:0]          right_average,
  output logic [LEVEL_W-1:0]          left_average,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [LEVEL_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(BLOCK_SAMPLES + 1);

  levels_t                levels;
  logic [CNT_W-1:0]       samples_taken;
  lane_ctl_t              ctl;
  logic [SAMPLE_BITS-1:0] right_mean;
  logic [SAMPLE_BITS-1:0] left_mean;
  result_t                res;
  result_t                queue [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             fill;
  logic                   pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels.left_release  <= LEFT_RELEASE_RST;
      levels.left_trigger  <= LEFT_TRIGGER_RST;
      levels.right_release <= RIGHT_RELEASE_RST;
      levels.right_trigger <= RIGHT_TRIGGER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEFT_RELEASE:  levels.left_release  <= cfg_data;
        CFG_LEFT_TRIGGER:  levels.left_trigger  <= cfg_data;
        CFG_RIGHT_RELEASE: levels.right_release <= cfg_data;
        CFG_RIGHT_TRIGGER: levels.right_trigger <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready  = (fill != 2'd2);
  assign ctl.take  = in_valid && in_ready;
  assign ctl.flush = (samples_taken == CNT_W'(BLOCK_SAMPLES));

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_taken <= '0;
    end else if (ctl.take) begin
      samples_taken <= ctl.flush ? '0 : samples_taken + 1'b1;
    end
  end

  gdt_lane #(
    .BLOCK_SAMPLES(BLOCK_SAMPLES),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_right_lane (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sample  (right_sample),
    .mean_now(right_mean)
  );

  gdt_lane #(
    .BLOCK_SAMPLES(BLOCK_SAMPLES),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_left_lane (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sample  (left_sample),
    .mean_now(left_mean)
  );

  gdt_dir #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dir (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .levels    (levels),
    .right_mean(right_mean),
    .left_mean (left_mean),
    .res       (res)
  );

  // two-entry result queue
  assign pop       = out_valid && out_ready;
  assign out_valid = (fill != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (ctl.take) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({ctl.take, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      queue[wr_ptr] <= res;
    end
  end

  always_comb begin
    gaze_direction    = queue[rd_ptr].gaze_direction;
    direction_changed = queue[rd_ptr].direction_changed;
    reported_level    = queue[rd_ptr].reported_level;
    averages_updated  = queue[rd_ptr].averages_updated;
    right_average     = queue[rd_ptr].right_average;
    left_average      = queue[rd_ptr].left_average;
  end

endmodule

`default_nettype wire

>>> hw/rtl/gdt_checker.sv
// ---------------------------------------------------------------------------
// gdt_checker
// port-level checks for the gaze tracker, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "dual_channel_gaze_direction_tracker_macros.svh"

module gdt_checker import gdt_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               direction_changed,
  input wire logic [LEVEL_W-1:0] reported_level
);

  `GDT_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `GDT_ASSERT(a_level_zero, clk, rst, out_valid && !direction_changed |-> reported_level == '0, "level reported without a change")
  `GDT_ASSERT(a_full_means_pending, clk, rst, !in_ready |-> out_valid, "input blocked with no result pending")
  `GDT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && in_ready, "queue not empty after reset")

endmodule

bind dual_channel_gaze_direction_tracker gdt_checker u_gdt_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .direction_changed(direction_changed),
  .reported_level   (reported_level)
);

`default_nettype wire

>>> tb/sv/dual_channel_gaze_direction_tracker_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gaze direction tracker testbench
// Sends poll requests with random gaps and throttles the result side, rewrites
// the four threshold levels between phases, and checks every result request
// against directed values or a local model of block averaging and hysteresis.
// ---------------------------------------------------------------------------

module dual_channel_gaze_direction_tracker_tb import gdt_pkg::*; ();

  localparam int BLOCK_LEN   = BLOCK_SAMPLES_DEF;
  localparam int ACC_W       = 14;
  localparam int LEVEL_MAX   = (1 << LEVEL_W) - 1;
  localparam int GAP_MAX     = 11;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 600;
  localparam int PHASES      = 8;
  localparam int PHASE_POLLS = 250;
  localparam int CYCLE_LIMIT = 500000;
  localparam int REPORT_MAX  = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [4:0]           count;
    logic [CFG_IDX_W-1:0] index;
    logic [LEVEL_W-1:0]   right_s;
    logic [LEVEL_W-1:0]   left_s;
    logic                 typed;
    result_t              exp;
  } row_t;

  localparam result_t NO_EXP = '0;

  // config rows carry the register value in right_s
  localparam int ROWS = 11;
  localparam row_t DIRECTED [ROWS] = '{
    // means start at zero, so the first request turns right
    '{ROW_POLL, 5'd1, '0, 10'd1023, 10'd0, 1'b1,
      '{GAZE_RIGHT, 1'b1, 10'd0, 1'b0, 10'd0, 10'd0}},
    '{ROW_POLL, 5'd1, '0, 10'd1023, 10'd0, 1'b1,
      '{GAZE_RIGHT, 1'b0, 10'd0, 1'b0, 10'd0, 10'd0}},
    '{ROW_POLL, 5'd14, '0, 10'd1023, 10'd0, 1'b0, NO_EXP},
    // refresh request drops its samples, full right mean releases right
    '{ROW_POLL, 5'd1, '0, 10'd0, 10'd1023, 1'b1,
      '{GAZE_CENTER, 1'b1, 10'd1023, 1'b1, 10'd1023, 10'd0}},
    '{ROW_POLL, 5'd1, '0, 10'd512, 10'd512, 1'b1,
      '{GAZE_LEFT, 1'b1, 10'd0, 1'b0, 10'd1023, 10'd0}},
    '{ROW_POLL, 5'd1, '0, 10'd0, 10'd0, 1'b1,
      '{GAZE_LEFT, 1'b0, 10'd0, 1'b0, 10'd1023, 10'd0}},
    '{ROW_CFG, 5'd1, CFG_UNUSED_LO, 10'd0, 10'd0, 1'b0, NO_EXP},
    '{ROW_CFG, 5'd1, CFG_LEFT_RELEASE, 10'd1023, 10'd0, 1'b0, NO_EXP},
    '{ROW_CFG, 5'd1, CFG_UNUSED_HI, 10'd1023, 10'd0, 1'b0, NO_EXP},
    '{ROW_POLL, 5'd1, '0, 10'd1023, 10'd1023, 1'b0, NO_EXP},
    '{ROW_POLL, 5'd2, '0, 10'd0, 10'd1023, 1'b0, NO_EXP}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [LEVEL_W-1:0]   right_sample = '0;
  logic [LEVEL_W-1:0]   left_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           gaze_direction;
  logic                 direction_changed;
  logic [LEVEL_W-1:0]   reported_level;
  logic                 averages_updated;
  logic [LEVEL_W-1:0]   right_average;
  logic [LEVEL_W-1:0]   left_average;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEVEL_W-1:0]   cfg_data = '0;

  dual_channel_gaze_direction_tracker DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  logic [LEVEL_W-1:0] lvl_left_release  = LEFT_RELEASE_RST;
  logic [LEVEL_W-1:0] lvl_left_trigger  = LEFT_TRIGGER_RST;
  logic [LEVEL_W-1:0] lvl_right_release = RIGHT_RELEASE_RST;
  logic [LEVEL_W-1:0] lvl_right_trigger = RIGHT_TRIGGER_RST;
  logic [4:0]         acc_count = '0;
  logic [ACC_W-1:0]   right_acc = '0;
  logic [ACC_W-1:0]   left_acc = '0;
  logic [LEVEL_W-1:0] right_avg = '0;
  logic [LEVEL_W-1:0] left_avg = '0;
  dir_t               dir_now = GAZE_CENTER;

  result_t gaze_reports_due [$];
  int      reports_seen = 0;
  int      bad_reports = 0;
  int      stray_reports = 0;
  int      cycle_count = 0;
  bit      no_gaps = 1'b0;
  logic    poll_typed = 1'b0;
  result_t poll_exp = '0;

  function automatic result_t track_gaze(input logic [LEVEL_W-1:0] rs, ls);
    result_t r;
    r = '0;
    if (acc_count < BLOCK_LEN) begin
      right_acc += ACC_W'(rs);
      left_acc  += ACC_W'(ls);
      acc_count++;
    end else begin
      right_avg = LEVEL_W'(right_acc / BLOCK_LEN);
      left_avg  = LEVEL_W'(left_acc / BLOCK_LEN);
      right_acc = '0;
      left_acc  = '0;
      acc_count = '0;
      r.averages_updated = 1'b1;
    end
    case (dir_now)
      GAZE_CENTER: begin
        if (right_avg < lvl_right_trigger) begin
          dir_now = GAZE_RIGHT;
          r.direction_changed = 1'b1;
          r.reported_level = right_avg;
        end else if (left_avg < lvl_left_trigger) begin
          dir_now = GAZE_LEFT;
          r.direction_changed = 1'b1;
          r.reported_level = left_avg;
        end
      end
      GAZE_RIGHT: begin
        if (right_avg > lvl_right_release) begin
          dir_now = GAZE_CENTER;
          r.direction_changed = 1'b1;
          r.reported_level = right_avg;
        end
      end
      GAZE_LEFT: begin
        if (left_avg > lvl_left_release) begin
          dir_now = GAZE_CENTER;
          r.direction_changed = 1'b1;
          r.reported_level = left_avg;
        end
      end
      default: ;
    endcase
    r.gaze_direction = dir_now;
    r.right_average = right_avg;
    r.left_average = left_avg;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t due;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LEFT_RELEASE:  lvl_left_release  = cfg_data;
          CFG_LEFT_TRIGGER:  lvl_left_trigger  = cfg_data;
          CFG_RIGHT_RELEASE: lvl_right_release = cfg_data;
          CFG_RIGHT_TRIGGER: lvl_right_trigger = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        due = track_gaze(right_sample, left_sample);
        if (poll_typed)
          due = poll_exp;
        gaze_reports_due.push_back(due);
      end
      if (out_valid && out_ready) begin
        seen = {gaze_direction, direction_changed, reported_level, averages_updated,
                right_average, left_average};
        if (gaze_reports_due.size() == 0) begin
          stray_reports++;
          if (bad_reports + stray_reports <= REPORT_MAX)
            $display("unexpected result request: dir %0d chg %0d lvl %0d",
                     seen.gaze_direction, seen.direction_changed, seen.reported_level);
        end else begin
          due = gaze_reports_due.pop_front();
          if (seen !== due) begin
            bad_reports++;
            if (bad_reports + stray_reports <= REPORT_MAX)
              $display({"result %0d: expected dir %0d chg %0d lvl %0d upd %0d r %0d l %0d,",
                        " got dir %0d chg %0d lvl %0d upd %0d r %0d l %0d"},
                       reports_seen, due.gaze_direction, due.direction_changed,
                       due.reported_level, due.averages_updated, due.right_average,
                       due.left_average, seen.gaze_direction, seen.direction_changed,
                       seen.reported_level, seen.averages_updated, seen.right_average,
                       seen.left_average);
          end
          reports_seen++;
        end
      end
    end
  end

  function automatic logic [LEVEL_W-1:0] clamp_level(input int v);
    if (v < 0)
      return '0;
    if (v > LEVEL_MAX)
      return LEVEL_W'(LEVEL_MAX);
    return LEVEL_W'(v);
  endfunction

  // block level for one channel: near one of its thresholds, a rail, or noise (-1)
  function automatic int draw_base(input logic [LEVEL_W-1:0] lvl_a, lvl_b);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6)
      return int'(clamp_level(int'((pick % 2) ? lvl_a : lvl_b)
                              + int'($urandom_range(0, 80)) - 40));
    if (pick == 6)
      return 0;
    if (pick == 7)
      return LEVEL_MAX;
    return -1;
  endfunction

  function automatic logic [LEVEL_W-1:0] draw_sample(input int base);
    if (base < 0)
      return LEVEL_W'($urandom_range(0, LEVEL_MAX));
    return clamp_level(base + int'($urandom_range(0, 16)) - 8);
  endfunction

  function automatic logic [LEVEL_W-1:0] draw_threshold(input int phase);
    int pick;
    if (phase == 0)
      return '0;
    if (phase == 1)
      return LEVEL_W'(LEVEL_MAX);
    pick = $urandom_range(0, 9);
    if (pick == 0)
      return '0;
    if (pick == 1)
      return LEVEL_W'(LEVEL_MAX);
    return LEVEL_W'($urandom_range(0, LEVEL_MAX));
  endfunction

  task automatic send_poll(input logic [LEVEL_W-1:0] rs, ls, input logic typed,
                           input result_t exp);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    right_sample <= rs;
    left_sample <= ls;
    poll_typed <= typed;
    poll_exp <= exp;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop the request line and wait until every result request is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (gaze_reports_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_level(input logic [CFG_IDX_W-1:0] idx,
                             input logic [LEVEL_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // result side: random gaps, one long hold-off so the block backs up
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
      if (!held && reports_seen >= HOLD_AFTER) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int right_base;
    int left_base;
    right_base = -1;
    left_base = -1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        settle();
        write_level(DIRECTED[i].index, DIRECTED[i].right_s);
      end else begin
        repeat (DIRECTED[i].count)
          send_poll(DIRECTED[i].right_s, DIRECTED[i].left_s, DIRECTED[i].typed,
                    DIRECTED[i].exp);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      no_gaps = (p == 2) || (p == 5);
      write_level(CFG_LEFT_RELEASE, draw_threshold(p));
      write_level(CFG_LEFT_TRIGGER, draw_threshold(p));
      write_level(CFG_RIGHT_RELEASE, draw_threshold(p));
      write_level(CFG_RIGHT_TRIGGER, draw_threshold(p));
      // an unmapped index must leave the levels alone
      write_level(CFG_IDX_W'(CFG_UNUSED_LO + $urandom_range(0, 3)),
                  LEVEL_W'($urandom_range(0, LEVEL_MAX)));
      for (int k = 0; k < PHASE_POLLS; k++) begin
        if (k % (BLOCK_LEN + 1) == 0) begin
          right_base = draw_base(lvl_right_trigger, lvl_right_release);
          left_base = draw_base(lvl_left_trigger, lvl_left_release);
        end
        send_poll(draw_sample(right_base), draw_sample(left_base), 1'b0, NO_EXP);
      end
    end

    settle();
    if (bad_reports == 0 && stray_reports == 0 && gaze_reports_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
